/* rtl/uv_pkg.sv */
// Shared types, codes and helpers for the UTF-8 string validator.
// Used by every module of the block; depends on nothing else.
package uv_pkg;

   // Result codes for the error kind field.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NUL       = 3'd1;
   localparam logic [2:0] ERR_BAD_LEAD  = 3'd2;
   localparam logic [2:0] ERR_BAD_CONT  = 3'd3;
   localparam logic [2:0] ERR_TRUNC     = 3'd4;
   localparam logic [2:0] ERR_OVERLONG  = 3'd5;
   localparam logic [2:0] ERR_RANGE     = 3'd6;
   localparam logic [2:0] ERR_SURROGATE = 3'd7;

   // Byte classes produced by the front end.
   localparam logic [2:0] CLS_NUL      = 3'd0;
   localparam logic [2:0] CLS_ASCII    = 3'd1;
   localparam logic [2:0] CLS_CONT     = 3'd2;
   localparam logic [2:0] CLS_LEAD2    = 3'd3;
   localparam logic [2:0] CLS_LEAD3    = 3'd4;
   localparam logic [2:0] CLS_LEAD4    = 3'd5;
   localparam logic [2:0] CLS_BAD_LEAD = 3'd6;

   // Code point limits.
   localparam int unsigned CP_W = 21;
   localparam logic [CP_W-1:0] CP_MIN_3BYTE  = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_4BYTE  = 21'h010000;
   localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
   localparam logic [CP_W-1:0] CP_SURR_FIRST = 21'h00D800;
   localparam logic [CP_W-1:0] CP_SURR_LAST  = 21'h00DFFF;

   // Default depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      logic [2:0] cls;
      logic [5:0] bits;
      logic       last;
   } cls_item_type;

   // Checks a finished multibyte character. len is its continuation count.
   function automatic logic [2:0] check_complete(input logic [1:0] len,
                                                 input logic [CP_W-1:0] cp);
      logic [2:0] err;
      err = ERR_NONE;
      if ((len == 2'd2 && cp < CP_MIN_3BYTE) || (len == 2'd3 && cp < CP_MIN_4BYTE)) begin
         err = ERR_OVERLONG;
      end else if (cp > CP_MAX) begin
         err = ERR_RANGE;
      end else if (cp >= CP_SURR_FIRST && cp <= CP_SURR_LAST) begin
         err = ERR_SURROGATE;
      end
      return err;
   endfunction

endpackage

/* rtl/utf8_string_validator.sv */
// Top level of the UTF-8 string validator: front classifier, queue and back end.
// Depends on uv_pkg, uv_front, uv_queue and uv_back.
//
// Usage:
//   The request channel carries one byte of a string per beat, with
//   req_last_byte high on the final byte. Every string has at least one byte.
//   The response channel carries one beat per string: rsp_valid_res is high
//   when the string is strict UTF-8, and rsp_error_kind gives the first error
//   found in byte order (none, NUL, bad lead, bad continuation, truncated,
//   overlong, above range, surrogate).
//   Throughput is one byte per cycle while req_ready is high, set by the
//   per-byte state update in the back end. rsp_valid rises once the beat
//   of the last byte has been accepted, has waited in the queue and is
//   checked as it leaves, straight into the response register.
//   When the receiver stalls, the response register holds its beat; bytes
//   of the next string keep flowing until the next last byte reaches the
//   back end, and then the queue of QUEUE_DEPTH entries fills before
//   req_ready drops.
//   Reset empties the queue, clears the response valid flag and the sequence
//   state, so the first beat after reset starts a new string.
module utf8_string_validator #(
   parameter int unsigned QUEUE_DEPTH = uv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res,
   output logic [2:0] rsp_error_kind
);

   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   uv_pkg::cls_item_type push_item, pop_item;

   // Byte classification.
   uv_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   // Decoupling queue.
   uv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Sequence checking and response.
   uv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_error_kind (rsp_error_kind)
   );

endmodule

/* rtl/uv_front.sv */
// Front end of the UTF-8 string validator: takes request beats and
// classifies each byte for the back end. Depends on uv_pkg.
module uv_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   output logic                 push_valid,
   input  logic                 push_ready,
   output uv_pkg::cls_item_type push_item
);

   // The queue takes a beat whenever it has room.
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // Classify the byte and keep only its payload bits.
   always_comb begin
      push_item.last = req_last_byte;
      push_item.bits = req_data_byte[5:0];
      if (req_data_byte == 8'h00) begin
         push_item.cls = uv_pkg::CLS_NUL;
      end else if (req_data_byte[7] == 1'b0) begin
         push_item.cls = uv_pkg::CLS_ASCII;
      end else if (req_data_byte[7:6] == 2'b10) begin
         push_item.cls = uv_pkg::CLS_CONT;
      end else if (req_data_byte[7:5] == 3'b110) begin
         // C0 and C1 could only ever encode overlong forms.
         push_item.cls  = (req_data_byte[4:1] == 4'd0) ? uv_pkg::CLS_BAD_LEAD
                                                       : uv_pkg::CLS_LEAD2;
         push_item.bits = {1'b0, req_data_byte[4:0]};
      end else if (req_data_byte[7:4] == 4'b1110) begin
         push_item.cls  = uv_pkg::CLS_LEAD3;
         push_item.bits = {2'b00, req_data_byte[3:0]};
      end else if (req_data_byte[7:3] == 5'b11110) begin
         push_item.cls  = uv_pkg::CLS_LEAD4;
         push_item.bits = {3'b000, req_data_byte[2:0]};
      end else begin
         push_item.cls = uv_pkg::CLS_BAD_LEAD;
      end
   end

endmodule

/* rtl/uv_queue.sv */
// Small first-in first-out queue of classified bytes between front and back.
// Depends on uv_pkg for the item type.
module uv_queue #(
   parameter int unsigned DEPTH = uv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  uv_pkg::cls_item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output uv_pkg::cls_item_type pop_item
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   uv_pkg::cls_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/uv_back.sv */
// Back end of the UTF-8 string validator: sequence state, first-error latch
// and the registered response. Depends on uv_pkg.
module uv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  uv_pkg::cls_item_type pop_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_valid_res,
   output logic [2:0]           rsp_error_kind
);

   logic [1:0]              pending_ff, pending_in;
   logic [1:0]              seq_len_ff, seq_len_in;
   logic [uv_pkg::CP_W-1:0] acc_ff, acc_in;
   logic [2:0]              err_ff, err_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_res_ff, out_res_in;
   logic [2:0]              out_kind_ff, out_kind_in;
   logic [uv_pkg::CP_W-1:0] acc_shift;
   logic [2:0]              final_err;
   logic                    do_pop;

   // A beat that ends a string needs the response register free.
   assign pop_ready = !pop_item.last || !out_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign acc_shift = {acc_ff[uv_pkg::CP_W-7:0], pop_item.bits};

   // Per-byte state update; bytes after a latched error are ignored.
   always_comb begin
      pending_in = pending_ff;
      seq_len_in = seq_len_ff;
      acc_in     = acc_ff;
      err_in     = err_ff;
      if (err_ff == uv_pkg::ERR_NONE) begin
         if (pending_ff != 2'd0) begin
            if (pop_item.cls != uv_pkg::CLS_CONT) begin
               err_in = uv_pkg::ERR_BAD_CONT;
            end else begin
               acc_in     = acc_shift;
               pending_in = pending_ff - 2'd1;
               if (pending_ff == 2'd1) begin
                  err_in = uv_pkg::check_complete(seq_len_ff, acc_shift);
               end
            end
         end else begin
            unique case (pop_item.cls)
               uv_pkg::CLS_NUL:   err_in = uv_pkg::ERR_NUL;
               uv_pkg::CLS_ASCII: err_in = uv_pkg::ERR_NONE;
               uv_pkg::CLS_LEAD2: begin
                  seq_len_in = 2'd1;
                  pending_in = 2'd1;
                  acc_in     = uv_pkg::CP_W'(pop_item.bits);
               end
               uv_pkg::CLS_LEAD3: begin
                  seq_len_in = 2'd2;
                  pending_in = 2'd2;
                  acc_in     = uv_pkg::CP_W'(pop_item.bits);
               end
               uv_pkg::CLS_LEAD4: begin
                  seq_len_in = 2'd3;
                  pending_in = 2'd3;
                  acc_in     = uv_pkg::CP_W'(pop_item.bits);
               end
               default: err_in = uv_pkg::ERR_BAD_LEAD;
            endcase
         end
      end
   end

   // A string that ends inside a character is truncated.
   assign final_err = (err_in == uv_pkg::ERR_NONE && pending_in != 2'd0)
                      ? uv_pkg::ERR_TRUNC : err_in;

   // Response register: loaded on the last byte, held while stalled.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_res_in   = out_res_ff;
      out_kind_in  = out_kind_ff;
      if (do_pop && pop_item.last) begin
         out_valid_in = 1'b1;
         out_res_in   = (final_err == uv_pkg::ERR_NONE);
         out_kind_in  = final_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         seq_len_ff   <= '0;
         acc_ff       <= '0;
         err_ff       <= uv_pkg::ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (do_pop) begin
            if (pop_item.last) begin
               // Start the next string from a clean state.
               pending_ff <= '0;
               seq_len_ff <= '0;
               acc_ff     <= '0;
               err_ff     <= uv_pkg::ERR_NONE;
            end else begin
               pending_ff <= pending_in;
               seq_len_ff <= seq_len_in;
               acc_ff     <= acc_in;
               err_ff     <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      out_kind_ff <= out_kind_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_valid_res  = out_res_ff;
   assign rsp_error_kind = out_kind_ff;

endmodule

/* sim/utf8_string_validator_tb.sv */
// Self-checking testbench for utf8_string_validator: strings are streamed in a byte per
// beat and each verdict is compared with a predictor kept inside the testbench.
// Depends on uv_pkg and the utf8_string_validator RTL.
`timescale 1ns / 1ps

module utf8_string_validator_tb;

   typedef struct {
      logic       valid_res;
      logic [2:0] error_kind;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_valid_res;
   logic [2:0] rsp_error_kind;

   // Predictor state, mirrors the decoder state of the block.
   logic [1:0]  pend_cnt = 2'd0;
   logic [1:0]  seq_len = 2'd0;
   logic [20:0] cp_acc = 21'd0;
   logic [2:0]  latched_err = uv_pkg::ERR_NONE;

   verdict_type verdict_queue[$];
   logic [7:0]  string_bytes[$];
   int          send_gap_pct = 0;
   int          rcv_stall_pct = 0;
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          strings_sent = 0;
   int          verdicts_checked = 0;

   utf8_string_validator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_error_kind (rsp_error_kind)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Checks a finished multibyte character; cont_count is its continuation count.
   function automatic logic [2:0] code_point_fault(input logic [1:0] cont_count,
                                                   input logic [20:0] cp);
      logic [20:0] floor_cp;
      unique case (cont_count)
         2'd2: floor_cp = 21'h000800;
         2'd3: floor_cp = 21'h010000;
         default: floor_cp = 21'h000000;
      endcase
      if (cp < floor_cp) return uv_pkg::ERR_OVERLONG;
      if (cp > 21'h10FFFF) return uv_pkg::ERR_RANGE;
      // D800..DFFF share the upper ten bits.
      if (cp[20:11] == 10'h01B) return uv_pkg::ERR_SURROGATE;
      return uv_pkg::ERR_NONE;
   endfunction

   // Adds one byte to the end of the string being built.
   task automatic append_byte(input logic [7:0] b);
      string_bytes = {string_bytes, b};
   endtask

   // Updates the predicted decoder state with one accepted byte.
   task automatic predict_byte(input logic [7:0] b, input logic lst);
      verdict_type v;
      if (latched_err == uv_pkg::ERR_NONE) begin
         if (pend_cnt != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               latched_err = uv_pkg::ERR_BAD_CONT;
            end else begin
               cp_acc = {cp_acc[14:0], b[5:0]};
               pend_cnt = pend_cnt - 2'd1;
               if (pend_cnt == 2'd0) latched_err = code_point_fault(seq_len, cp_acc);
            end
         end else if (b == 8'h00) begin
            latched_err = uv_pkg::ERR_NUL;
         end else if (!b[7]) begin
            // Plain ASCII character, nothing to track.
         end else if (b[7:5] == 3'b110) begin
            if (b[4:1] == 4'b0000) begin
               latched_err = uv_pkg::ERR_BAD_LEAD;
            end else begin
               seq_len = 2'd1;
               pend_cnt = 2'd1;
               cp_acc = {16'd0, b[4:0]};
            end
         end else if (b[7:4] == 4'b1110) begin
            seq_len = 2'd2;
            pend_cnt = 2'd2;
            cp_acc = {17'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            seq_len = 2'd3;
            pend_cnt = 2'd3;
            cp_acc = {18'd0, b[2:0]};
         end else begin
            latched_err = uv_pkg::ERR_BAD_LEAD;
         end
      end
      if (lst) begin
         if (latched_err == uv_pkg::ERR_NONE && pend_cnt != 2'd0) begin
            latched_err = uv_pkg::ERR_TRUNC;
         end
         v.valid_res = (latched_err == uv_pkg::ERR_NONE);
         v.error_kind = latched_err;
         verdict_queue = {verdict_queue, v};
         pend_cnt = 2'd0;
         seq_len = 2'd0;
         cp_acc = 21'd0;
         latched_err = uv_pkg::ERR_NONE;
      end
   endtask

   // Drives one byte beat and records its effect once it is accepted.
   task automatic send_byte(input logic [7:0] b, input logic lst);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_last_byte = lst;
      do @(posedge clock); while (!req_ready);
      predict_byte(b, lst);
      bytes_sent++;
      if (lst) strings_sent++;
      @(negedge clock);
   endtask

   // Sends the collected string, marking its final byte.
   task automatic send_string();
      foreach (string_bytes[i]) send_byte(string_bytes[i], i == string_bytes.size() - 1);
      string_bytes.delete();
   endtask

   task automatic load_string(input logic [7:0] bytes_in[]);
      foreach (bytes_in[i]) append_byte(bytes_in[i]);
      send_string();
   endtask

   // Appends the first keep bytes of an n-byte encoding of cp; oversized n gives overlong forms.
   task automatic push_code_point(input logic [20:0] cp, input int n, input int keep);
      logic [7:0] seq[4];
      case (n)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) append_byte(seq[i]);
   endtask

   // Receiver pacing: rsp_ready changes on the falling edge only.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
   end

   // Compares every accepted verdict beat with the oldest prediction.
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_queue.size() == 0) begin
            $error("Verdict beat arrived with no string outstanding");
            fail_count++;
         end else begin
            v = verdict_queue.pop_front();
            verdicts_checked++;
            if (rsp_valid_res !== v.valid_res) begin
               $error("rsp_valid_res: expected %0d, got %0d", v.valid_res, rsp_valid_res);
               fail_count++;
            end
            if (rsp_error_kind !== v.error_kind) begin
               $error("rsp_error_kind: expected %0d, got %0d", v.error_kind, rsp_error_kind);
               fail_count++;
            end
         end
      end
   end

   // Hand-picked strings: every error kind, field extremes and boundary cases.
   task automatic test_directed();
      load_string('{8'h7F, 8'hC2, 8'h80});        // largest ASCII, then smallest 2-byte
      load_string('{8'h00});                      // NUL as a lead byte
      load_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF}); // top code point, ends on the last byte
      load_string('{8'hED, 8'hA0, 8'h80});        // surrogate
      load_string('{8'hF5, 8'h80, 8'h80, 8'h80}); // F5 lead gives above range
      load_string('{8'hE0, 8'h80, 8'h80});        // overlong three-byte form
      load_string('{8'hFF});                      // invalid lead byte
      load_string('{8'hC2, 8'h00});               // NUL where a continuation belongs
      load_string('{8'hE2, 8'h82});               // cut short at the end
      load_string('{8'hC1, 8'hBF});               // C1 lead, trailing byte ignored
   endtask

   // Random strings, about half of them built well-formed, until the byte budget is spent.
   task automatic test_random_strings(input int byte_budget);
      int          stop_at;
      int          nchars;
      int          roll;
      int          n;
      bit          clean;
      logic [20:0] cp;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         nchars = $urandom_range(1, 6);
         clean = 1'($urandom_range(1));
         for (int c = 0; c < nchars; c++) begin
            roll = clean ? $urandom_range(74) : $urandom_range(99);
            if (roll < 30) begin
               push_code_point(21'($urandom_range(1, 8'h7F)), 1, 1);
            end else if (roll < 50) begin
               push_code_point(21'($urandom_range(12'h080, 12'h7FF)), 2, 2);
            end else if (roll < 65) begin
               cp = 21'($urandom_range(16'h0800, 16'hF7FF));
               if (cp >= 21'h00D800) cp = cp + 21'h000800;
               push_code_point(cp, 3, 3);
            end else if (roll < 75) begin
               push_code_point(21'($urandom_range(21'h010000, 21'h10FFFF)), 4, 4);
            end else if (roll < 80) begin
               // Overlong: value fits in a shorter form.
               n = $urandom_range(2, 4);
               case (n)
                  2: cp = 21'($urandom_range(8'h7F));
                  3: cp = 21'($urandom_range(12'h7FF));
                  default: cp = 21'($urandom_range(16'hFFFF));
               endcase
               push_code_point(cp, n, n);
            end else if (roll < 84) begin
               push_code_point(21'($urandom_range(16'hD800, 16'hDFFF)), 3, 3);
            end else if (roll < 87) begin
               push_code_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
            end else if (roll < 90) begin
               // Multibyte character with its tail dropped.
               n = $urandom_range(2, 4);
               push_code_point(21'($urandom_range(21'h010000, 21'h10FFFF)), n,
                               $urandom_range(1, n - 1));
            end else if (roll < 95) begin
               append_byte(8'($urandom_range(8'hFF)));
            end else if (roll < 97) begin
               append_byte(8'h00);
            end else begin
               append_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
         end
         send_string();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Sender mostly busy, receiver mostly stalled.
      send_gap_pct = 9;
      rcv_stall_pct = 76;
      test_directed();
      test_random_strings(390);

      // Sender mostly idle, receiver mostly ready.
      send_gap_pct = 76;
      rcv_stall_pct = 9;
      test_random_strings(400);

      // Full rate on both sides.
      send_gap_pct = 0;
      rcv_stall_pct = 0;
      test_random_strings(390);

      req_valid = 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Streamed %0d strings (%0d bytes) under three pacing mixes.",
               strings_sent, bytes_sent);
      $display("%0d verdicts compared.", verdicts_checked);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #400000;
      $display("Timed out with %0d verdicts outstanding.", verdict_queue.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/uv_pkg.sv
rtl/uv_front.sv
rtl/uv_queue.sv
rtl/uv_back.sv
rtl/utf8_string_validator.sv
sim/utf8_string_validator_tb.sv
